// ===== rtl/core/qfrq_pkg.sv =====
// ----------------------------------------------------------------------------
// qfrq_pkg
// Shared sizes, codes and beat types of the fair request queue.
// ----------------------------------------------------------------------------
package qfrq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int SID_W    = 8;
  localparam int IN_PAY_W = 32;
  localparam int QCNT_W   = 5;
  localparam int QUANT_W  = 8;
  localparam int STAT_W   = 2;

  localparam int PAY_W  = (PAYLOAD_BITS < IN_PAY_W) ? PAYLOAD_BITS : IN_PAY_W;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd1;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_NEXT   = 1'b1;

  localparam logic [STAT_W-1:0] ST_SUBMITTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_GRANTED   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic [QUANT_W-1:0] RUN_MAX = 8'd255;

  typedef struct packed {
    logic                action;
    logic [SID_W-1:0]    session_id;
    logic [IN_PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [SID_W-1:0]    out_session;
    logic [IN_PAY_W-1:0] out_payload;
    logic [QCNT_W-1:0]   queue_count;
  } rsp_t;

  typedef struct packed {
    logic [SID_W-1:0] session;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/qfrq_req_if.sv =====
// ----------------------------------------------------------------------------
// qfrq_req_if
// Request channel: valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface qfrq_req_if import qfrq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qfrq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qfrq_rsp_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface qfrq_rsp_if import qfrq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/qfrq_ram.sv =====
// ----------------------------------------------------------------------------
// qfrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/qfrq_cfg.sv =====
// ----------------------------------------------------------------------------
// qfrq_cfg
// APB register block holding the fairness quantum.
// ----------------------------------------------------------------------------
module qfrq_cfg import qfrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [QUANT_W-1:0]    quantum
);

  logic [QUANT_W-1:0] quantum_r;
  logic [QUANT_W-1:0] quantum_nxt;
  logic               hit;

  assign hit    = (paddr[CFG_ADDR_W-1] == REG_QUANTUM);
  assign pready = 1'b1;

  always_comb begin
    quantum_nxt = quantum_r;
    if (psel && penable && pwrite && hit) begin
      quantum_nxt = pwdata[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else begin
      quantum_r <= quantum_nxt;
    end
  end

  assign prdata  = hit ? CFG_DATA_W'(quantum_r) : '0;
  assign quantum = quantum_r;

endmodule

// ===== rtl/core/qfrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfrq_ctrl
// Queue sequencer: submit, fairness scan, grant and in-place compaction
// over the entry RAM held as a ring with a head pointer.
// ----------------------------------------------------------------------------
module qfrq_ctrl import qfrq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  qfrq_req_if.sink           in_if,
  input  logic [QUANT_W-1:0] quantum,
  output logic               res_valid,
  input  logic               res_ready,
  output rsp_t               res,
  output ram_req_t           ram_req,
  input  entry_t             ram_rdata
);

  localparam int SUM_W = ADDR_W + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_MRD  = 7'b0010000,
    S_MWR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  req_t               item_r, item_nxt;
  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SID_W-1:0]   last_session_r, last_session_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [QUANT_W-1:0] run_r, run_nxt;
  logic               search_r, search_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  entry_t             grant_r, grant_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;

  logic [QUANT_W-1:0] q_eff;
  logic [ADDR_W-1:0]  idx_plus;
  logic [CNT_W-1:0]   idx_next_c;
  logic               more_c;
  logic               more2_c;
  logic               hit;
  entry_t             gsel;

  assign q_eff      = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign idx_plus   = idx_r + ADDR_W'(1);
  assign idx_next_c = CNT_W'(idx_r) + CNT_W'(1);
  assign more_c     = (idx_next_c < count_r);
  assign more2_c    = ((CNT_W'(idx_r) + CNT_W'(2)) < count_r);
  assign hit        = search_r && (ram_rdata.session != last_session_r);
  assign gsel       = (hit || (idx_r == '0)) ? ram_rdata : grant_r;

  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    last_session_nxt = last_session_r;
    last_valid_nxt   = last_valid_r;
    run_nxt          = run_r;
    search_nxt       = search_r;
    idx_nxt          = idx_r;
    grant_nxt        = grant_r;
    status_nxt       = status_r;
    ram_req.we       = 1'b0;
    ram_req.waddr    = ring_addr(head_r, idx_r);
    ram_req.wdata    = ram_rdata;
    ram_req.raddr    = ring_addr(head_r, idx_r);
    res_valid        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          item_nxt  = in_if.data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.action == ACT_SUBMIT) begin
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            status_nxt = ST_DROPPED;
          end else begin
            ram_req.we            = 1'b1;
            ram_req.waddr         = ring_addr(head_r, count_r[ADDR_W-1:0]);
            ram_req.wdata.session = item_r.session_id;
            ram_req.wdata.payload = item_r.payload[PAY_W-1:0];
            count_nxt             = count_r + CNT_W'(1);
            status_nxt            = ST_SUBMITTED;
          end
          state_nxt = S_DONE;
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt    = '0;
          search_nxt = (count_r > CNT_W'(1)) && last_valid_r && (run_r >= q_eff);
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (search_r && !hit && more_c) begin
          if (idx_r == '0) begin
            grant_nxt = ram_rdata;
          end
          idx_nxt   = idx_plus;
          state_nxt = S_RD;
        end else begin
          grant_nxt = gsel;
          if ((count_r == CNT_W'(1)) || hit || !last_valid_r ||
              (gsel.session != last_session_r)) begin
            run_nxt = QUANT_W'(1);
          end else if (run_r < RUN_MAX) begin
            run_nxt = run_r + QUANT_W'(1);
          end
          last_session_nxt = gsel.session;
          last_valid_nxt   = 1'b1;
          status_nxt       = ST_GRANTED;
          if (!hit || (idx_r == '0)) begin
            head_nxt  = ring_addr(head_r, ADDR_W'(1));
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else if (more_c) begin
            state_nxt = S_MRD;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_MRD: begin
        ram_req.raddr = ring_addr(head_r, idx_plus);
        state_nxt     = S_MWR;
      end
      S_MWR: begin
        ram_req.we = 1'b1;
        idx_nxt    = idx_plus;
        if (more2_c) begin
          state_nxt = S_MRD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_r         <= '0;
      count_r        <= '0;
      last_session_r <= '0;
      last_valid_r   <= 1'b0;
      run_r          <= '0;
      search_r       <= 1'b0;
      idx_r          <= '0;
      status_r       <= ST_SUBMITTED;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      last_session_r <= last_session_nxt;
      last_valid_r   <= last_valid_nxt;
      run_r          <= run_nxt;
      search_r       <= search_nxt;
      idx_r          <= idx_nxt;
      status_r       <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    grant_r <= grant_nxt;
  end

  always_comb begin
    res.status      = status_r;
    res.out_session = '0;
    res.out_payload = '0;
    res.queue_count = QCNT_W'(count_r);
    if (status_r == ST_GRANTED) begin
      res.out_session = grant_r.session;
      res.out_payload = IN_PAY_W'(grant_r.payload);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_run_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !last_valid_r |-> (run_r == '0))
    else $error("run length without a served session");

  a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == ST_GRANTED)) |->
      (last_valid_r && (res.out_session == last_session_r) && (run_r != '0)))
    else $error("grant beat disagrees with last session");

  a_submit_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (item_r.action == ACT_SUBMIT) &&
     (count_r != CNT_W'(QUEUE_DEPTH))) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("submit did not advance queue count");

endmodule

// ===== rtl/core/quantum_fair_request_queue.sv =====
// ----------------------------------------------------------------------------
// quantum_fair_request_queue
// Bounded request queue with a per-session fairness quantum: submit beats
// append at the tail, next beats grant the head or the oldest other session.
// Each request passes through the sequencer states EXEC and DONE and the output
// register; a grant also reads and compares each entry scanned past the head
// (RD, CMP) and reads and rewrites each entry shifted after removal (MRD, MWR).
// One request at a time: no new request is taken until the last result leaves DONE.
// Reset: queue empty, no session served, quantum 1; no RAM clearing pass.
// ----------------------------------------------------------------------------
module quantum_fair_request_queue import qfrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  qfrq_req_if.sink              in_if,
  qfrq_rsp_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [QUANT_W-1:0]  quantum;
  logic                res_valid;
  logic                res_ready;
  rsp_t                res;
  ram_req_t            ram_req;
  entry_t              ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rbits;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  qfrq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quantum (quantum)
  );

  qfrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .quantum   (quantum),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  qfrq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = ram_rbits;

  assign res_ready = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_if.ready);
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

endmodule

// ===== tb/qfrq_grant_checker.sv =====
// ----------------------------------------------------------------------------
// qfrq_grant_checker
// Watches the request, result and register ports of the fair request queue.
// It keeps its own copy of the queue, the served session and its run, and
// the quantum register. It predicts the result of every accepted request
// and compares each result beat, field by field, with the oldest
// prediction. Register reads are checked against the tracked quantum.
// ----------------------------------------------------------------------------
module qfrq_grant_checker import qfrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  qfrq_req_if                   req_tap,
  qfrq_rsp_if                   rsp_tap,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    err_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] QUANTUM_ADDR = CFG_ADDR_W'(4 * REG_QUANTUM);

  entry_t             waiting[$];
  rsp_t               owed_rsp[$];
  logic [SID_W-1:0]   last_sid;
  logic               last_ok;
  logic [QUANT_W-1:0] run_len;
  logic [QUANT_W-1:0] quantum;
  rsp_t               want;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    err_count++;
    if (err_count <= 10)
      $display("%0t ns %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
  endtask

  function automatic rsp_t grant_outcome(input req_t r);
    rsp_t               res;
    entry_t             e;
    int                 pick;
    logic               hop;
    logic [QUANT_W-1:0] q;
    res = '0;
    if (r.action == ACT_SUBMIT) begin
      if (waiting.size() >= QUEUE_DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        e.session = r.session_id;
        e.payload = r.payload[PAY_W-1:0];
        waiting.insert(waiting.size(), e);
        res.status = ST_SUBMITTED;
      end
    end else if (waiting.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      q    = (quantum == '0) ? QUANT_W'(1) : quantum;
      pick = 0;
      hop  = 1'b0;
      if (waiting.size() > 1 && last_ok && run_len >= q) begin
        for (int i = 0; i < waiting.size(); i++) begin
          if (!hop && waiting[i].session != last_sid) begin
            pick = i;
            hop  = 1'b1;
          end
        end
      end
      e = waiting[pick];
      if (waiting.size() == 1 || hop || !last_ok || e.session != last_sid)
        run_len = QUANT_W'(1);
      else if (run_len != RUN_MAX)
        run_len = run_len + 1'b1;
      last_sid = e.session;
      last_ok  = 1'b1;
      waiting.delete(pick);
      res.status      = ST_GRANTED;
      res.out_session = e.session;
      res.out_payload = IN_PAY_W'(e.payload);
    end
    res.queue_count = QCNT_W'(waiting.size());
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      waiting.delete();
      owed_rsp.delete();
      last_sid = '0;
      last_ok  = 1'b0;
      run_len  = '0;
      quantum  = QUANTUM_RST;
    end else begin
      if (rsp_tap.valid && rsp_tap.ready) begin
        if (owed_rsp.size() == 0) begin
          flag("result beat with nothing pending", '0, rsp_tap.data.out_payload);
        end else begin
          want = owed_rsp[0];
          owed_rsp.delete(0);
          if (rsp_tap.data.status !== want.status)
            flag("status", want.status, rsp_tap.data.status);
          if (rsp_tap.data.out_session !== want.out_session)
            flag("out_session", want.out_session, rsp_tap.data.out_session);
          if (rsp_tap.data.out_payload !== want.out_payload)
            flag("out_payload", want.out_payload, rsp_tap.data.out_payload);
          if (rsp_tap.data.queue_count !== want.queue_count)
            flag("queue_count", want.queue_count, rsp_tap.data.queue_count);
        end
      end
      if (psel && penable && pready && paddr == QUANTUM_ADDR) begin
        if (pwrite)
          quantum = pwdata[QUANT_W-1:0];
        else if (prdata !== CFG_DATA_W'(quantum))
          flag("quantum readback", CFG_DATA_W'(quantum), prdata);
      end
      if (req_tap.valid && req_tap.ready) begin
        want = grant_outcome(req_tap.data);
        owed_rsp.insert(owed_rsp.size(), want);
      end
    end
    pending = owed_rsp.size();
  end

endmodule

// ===== tb/tb_quantum_fair_request_queue.sv =====
// ----------------------------------------------------------------------------
// tb_quantum_fair_request_queue
// Drives the fair request queue with a directed opening (empty grant, full
// queue, drop, fairness hand-off, extreme ids and payloads), then random
// submit/grant phases under several quantum settings, and a long
// single-session run that saturates the run counter. The sender works in
// bursts, the receiver stalls on its own pattern with one long hold-off.
// ----------------------------------------------------------------------------
module tb_quantum_fair_request_queue import qfrq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] QUANTUM_ADDR = CFG_ADDR_W'(4 * REG_QUANTUM);
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    pending;
  int                    burst_left = 0;
  bit                    quiet = 1'b0;
  int                    stall_cycles = 0;
  int                    rsp_beats = 0;
  int                    hold_left = 0;
  bit                    hold_done = 1'b0;
  logic [15:0]           rx_tick = '0;

  qfrq_req_if in_if ();
  qfrq_rsp_if out_if ();

  quantum_fair_request_queue uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qfrq_grant_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_tap   (in_if),
    .rsp_tap   (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .err_count (mismatches),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic req_t mk(input logic act, input logic [SID_W-1:0] sid,
                              input logic [IN_PAY_W-1:0] pay);
    req_t r;
    r.action     = act;
    r.session_id = sid;
    r.payload    = pay;
    return r;
  endfunction

  function automatic req_t rand_req(input int sub_pct, input int pool);
    logic [SID_W-1:0] sid;
    if ($urandom_range(9) == 0)
      sid = SID_W'($urandom);
    else
      sid = SID_W'($urandom_range(pool - 1));
    return mk(($urandom_range(99) < sub_pct) ? ACT_SUBMIT : ACT_NEXT, sid,
              IN_PAY_W'($urandom));
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb(input logic wr, input logic [CFG_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= QUANTUM_ADDR;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_quantum(input logic [QUANT_W-1:0] q);
    apb(1'b1, {24'($urandom), q});
    apb(1'b0, '0);
  endtask

  // receiver: rotating stall pattern, one long hold-off mid-run
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && rsp_beats >= 600) begin
      hold_done    <= 1'b1;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_tick[8:7])
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= ($urandom_range(1) == 1);
        2'd2: out_if.ready <= ($urandom_range(3) == 0);
        default: out_if.ready <= rx_tick[1] ^ rx_tick[3];
      endcase
    end
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready)
      rsp_beats <= rsp_beats + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int ph_q[6]     = '{1, 2, 3, 0, 6, 128};
    int ph_sub[6]   = '{60, 75, 40, 55, 60, 50};
    int ph_pool[6]  = '{3, 4, 2, 3, 2, 8};
    bit ph_quiet[6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    ph_q[5]      = $urandom_range(4, 254);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apb(1'b0, '0);
    set_quantum(8'd0);
    send_req(mk(ACT_NEXT, 8'hA5, 32'hFFFF_FFFF));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_req(mk(ACT_SUBMIT, (i % 5 == 3) ? 8'hFF : ((i == 6) ? 8'h5A : 8'h00),
                  (i == 0) ? 32'h0 : ((i == 1) ? 32'hFFFF_FFFF : IN_PAY_W'($urandom))));
    repeat (7) send_req(mk(ACT_NEXT, 8'h00, 32'h0));

    for (int p = 0; p < 6; p++) begin
      drain();
      set_quantum(QUANT_W'(ph_q[p]));
      quiet = ph_quiet[p];
      repeat (120) send_req(rand_req(ph_sub[p], ph_pool[p]));
      if (p == 2) begin
        drain();
        set_quantum(8'd255);
        quiet = 1'b0;
        repeat (QUEUE_DEPTH) send_req(mk(ACT_NEXT, 8'h00, 32'h0));
        repeat (2) send_req(mk(ACT_SUBMIT, 8'h77, IN_PAY_W'($urandom)));
        repeat (260) begin
          send_req(mk(ACT_SUBMIT, 8'h77, IN_PAY_W'($urandom)));
          send_req(mk(ACT_NEXT, SID_W'($urandom), IN_PAY_W'($urandom)));
        end
        send_req(mk(ACT_SUBMIT, 8'h12, IN_PAY_W'($urandom)));
        repeat (4) send_req(mk(ACT_NEXT, 8'h00, 32'h0));
      end
    end

    drain();
    repeat (80) @(negedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
